### design/hpc_pkg.sv
// Shared types and constants for the multichannel heater PWM controller.
// No dependencies; imported by hpc_dp, hpc_ctrl and the top level (hpc_div does not use it).
package hpc_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PEND_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEN_W   = 31;
  localparam int unsigned OFF_W   = 10;
  localparam int unsigned HEAT_W  = 10;
  localparam int unsigned MAXD_W  = 16;
  localparam int unsigned CIU_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CFGI_W  = 4;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 24;

  localparam logic [PEND_W-1:0] NONE_PENDING = 8'hFF;
  localparam logic [PCT_W-1:0]  FULL_PERCENT = 7'd100;
  localparam logic [CIU_W-1:0]  CIU_RESET    = 4'd10;
  localparam logic [MAXD_W-1:0] MAXD_RESET   = 16'd60000;

  localparam logic [CFGI_W-1:0] REG_CHANNELS_IN_USE = 4'd0;
  localparam logic [CFGI_W-1:0] REG_MAX_EXT_DUR     = 4'd1;

  typedef enum logic [2:0] {
    OP_TICK, OP_ON, OP_OFF, OP_SET_PWM, OP_STEP_DOWN, OP_ALL_ON, OP_ALL_OFF, OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SINGLE, ST_WALK, ST_DIV_WAIT, ST_CHECK, ST_RESTACK, ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;      // capture input transaction
    logic use_ch;    // address the channel field instead of the walk index
    logic chan_upd;  // apply the op to the addressed channel
    logic div_start; // launch step-down division
    logic sum_clr;   // clear running phase sum
    logic rs_upd;    // write one restacked phase offset
    logic out_load;  // capture result
  } hpc_cmd_t;

  typedef struct packed {
    logic idx_end;   // walk index reached the active count
    logic need_div;  // addressed channel needs a division for step-down
    logic div_done;
    logic flag;      // a duty changed during this op
  } hpc_stat_t;

endpackage

### design/hpc_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit dividend by 7-bit divisor.
// Self-contained; instantiated by hpc_dp.
module hpc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [6:0]  div_r, div_nxt;
  logic [7:0]  trial;
  logic [7:0]  trial_sub;

  assign trial     = {rem_r, quo_r[15]};
  assign trial_sub = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd15;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial_sub[6:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[6:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

### design/hpc_dp.sv
// Datapath: channel state arrays, time base, phase math, restacking, step-down divide.
// Depends on hpc_pkg and hpc_div.
module hpc_dp #(
  parameter int unsigned CHANNELS  = 10,
  parameter int unsigned PERIOD_MS = 1000,
  parameter int unsigned IW        = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hpc_pkg::hpc_cmd_t          cmd,
  input  logic [IW-1:0]              idx,
  output hpc_pkg::hpc_stat_t         stat,
  input  logic [hpc_pkg::IN_W-1:0]   in_data,
  input  logic                       cfg_we,
  input  logic [hpc_pkg::CFGI_W-1:0] cfg_idx,
  input  logic [hpc_pkg::MAXD_W-1:0] cfg_wdata,
  output logic [hpc_pkg::OUT_W-1:0]  out_data
);
  import hpc_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [10:0] P11 = 11'(PERIOD_MS);
  localparam logic [9:0]  P_LAST = 10'(PERIOD_MS - 1);
  localparam logic [9:0]  WRAP_REM = 10'((64'd1 << 32) % PERIOD_MS);

  logic [CIU_W-1:0]  ciu_r;
  logic [MAXD_W-1:0] maxd_r;
  op_t               op_r;
  logic [3:0]        ch_r;
  logic [PCT_W-1:0]  pin_r;
  logic [LEN_W-1:0]  dur_r;
  logic [TIME_W-1:0] time_r;
  logic [9:0]        tmod_r, tmod_nxt;
  logic              newp_r;
  logic              flag_r;
  logic [9:0]        sum_r;
  logic [PCT_W-1:0]  readv_r;
  logic [HEAT_W-1:0] oheat_r;
  logic [PCT_W-1:0]  opct_r;

  logic [PCT_W-1:0]  pct_r   [CHANNELS];
  logic [PEND_W-1:0] pend_r  [CHANNELS];
  logic [TIME_W-1:0] start_r [CHANNELS];
  logic [LEN_W-1:0]  len_r   [CHANNELS];
  logic [OFF_W-1:0]  off_r   [CHANNELS];
  logic [CHANNELS-1:0] drive_r;

  logic [9:0] ot_tab [128];
  for (genvar g = 0; g < 128; g++) begin : g_ot
    assign ot_tab[g] = 10'((g * PERIOD_MS) / 100);
  end

  function automatic logic [9:0] wrap_add(input logic [9:0] a, input logic [9:0] b);
    logic [10:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= P11) s = s - P11;
    return s[9:0];
  endfunction

  logic [CNT_W-1:0] n_act;
  logic [AW-1:0]    addr;
  logic             ch_valid;
  logic [PCT_W-1:0]  cur_pct, np;
  logic [PEND_W-1:0] cur_pend, npend;
  logic [TIME_W-1:0] cur_start, nstart;
  logic [LEN_W-1:0]  cur_len, nlen;
  logic [OFF_W-1:0]  cur_off, eff_off;
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic              upd_ok, changed, bit_v;
  logic [10:0]       diff_a, diff_b;
  logic [9:0]        d_a, d_b, k, d_v;
  logic              div_done;
  logic [15:0]       quo;
  logic [16:0]       ext_sum;
  logic [HEAT_W+CHANNELS-1:0] heat_ext;

  assign n_act    = ({1'b0, ciu_r} > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : {1'b0, ciu_r};
  assign ch_valid = {1'b0, ch_r} < n_act;
  assign addr     = cmd.use_ch ? AW'(ch_r) : idx[AW-1:0];

  assign cur_pct   = pct_r[addr];
  assign cur_pend  = pend_r[addr];
  assign cur_start = start_r[addr];
  assign cur_len   = len_r[addr];
  assign cur_off   = off_r[addr];

  assign elapsed = time_r - cur_start;
  assign expired = elapsed >= {1'b0, cur_len};
  assign ext_sum = {1'b0, cur_len[15:0]} + {1'b0, quo};

  hpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cur_len[15:0]),
    .divisor  (cur_pct - 7'd1),
    .done     (div_done),
    .quotient (quo)
  );

  // next channel values for the addressed channel
  always_comb begin
    np     = cur_pct;
    npend  = cur_pend;
    nstart = cur_start;
    nlen   = cur_len;
    unique case (op_r) inside
      OP_TICK: begin
        if (expired) begin
          np    = '0;
          npend = NONE_PENDING;
        end
        if (newp_r && npend != NONE_PENDING) begin
          np    = npend[PCT_W-1:0];
          npend = NONE_PENDING;
        end
      end
      OP_ON, OP_ALL_ON: begin
        nlen   = dur_r;
        nstart = time_r;
        np     = FULL_PERCENT;
      end
      OP_OFF, OP_ALL_OFF: begin
        nlen = '0;
        np   = '0;
      end
      OP_SET_PWM: begin
        if (pin_r <= FULL_PERCENT) begin
          nlen   = dur_r;
          nstart = time_r;
          npend  = {1'b0, pin_r};
        end
      end
      OP_STEP_DOWN: begin
        if (cur_pct > 7'd1) begin
          np = cur_pct - 7'd1;
          if (cur_len >= {15'd0, maxd_r}) nlen = {15'd0, maxd_r};
          else if (ext_sum >= {1'b0, maxd_r}) nlen = {15'd0, maxd_r};
          else nlen = {14'd0, ext_sum};
        end else begin
          np   = '0;
          nlen = '0;
        end
      end
      default: ;
    endcase
  end

  assign upd_ok  = cmd.chan_upd && (!cmd.use_ch || ch_valid);
  assign changed = np != cur_pct;

  // phase of the addressed channel against the current time
  assign eff_off = (flag_r || changed) ? sum_r : cur_off;
  assign diff_a  = {1'b0, tmod_r} - {1'b0, eff_off};
  assign d_a     = diff_a[10] ? 10'(diff_a + P11) : diff_a[9:0];
  assign k       = eff_off - time_r[9:0];
  assign diff_b  = {1'b0, WRAP_REM} - {1'b0, k};
  assign d_b     = diff_b[10] ? 10'(diff_b + P11) : diff_b[9:0];
  assign d_v     = (time_r < {22'd0, eff_off}) ? d_b : d_a;
  assign bit_v   = (np != '0) && (d_v < ot_tab[np]);

  assign tmod_nxt = (time_r == '1) ? 10'd0 : ((tmod_r == P_LAST) ? 10'd0 : tmod_r + 10'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r   <= CIU_RESET;
      maxd_r  <= MAXD_RESET;
      op_r    <= OP_TICK;
      time_r  <= '0;
      tmod_r  <= '0;
      newp_r  <= 1'b0;
      flag_r  <= 1'b0;
      sum_r   <= '0;
      readv_r <= '0;
      drive_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pct_r[i]   <= '0;
        pend_r[i]  <= NONE_PENDING;
        start_r[i] <= '0;
        len_r[i]   <= '0;
        off_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CHANNELS_IN_USE: ciu_r  <= cfg_wdata[CIU_W-1:0];
          REG_MAX_EXT_DUR:     maxd_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        op_r    <= op_t'(in_data[2:0]);
        flag_r  <= 1'b0;
        sum_r   <= '0;
        readv_r <= '0;
        if (op_t'(in_data[2:0]) == OP_TICK) begin
          time_r <= time_r + 32'd1;
          tmod_r <= tmod_nxt;
          newp_r <= tmod_nxt == 10'd0;
        end
      end
      if (cmd.sum_clr) sum_r <= '0;
      if (upd_ok) begin
        pct_r[addr]   <= np;
        pend_r[addr]  <= npend;
        start_r[addr] <= nstart;
        len_r[addr]   <= nlen;
        if (changed) flag_r <= 1'b1;
        if (op_r == OP_READ) readv_r <= cur_pct;
        if (op_r == OP_TICK) begin
          drive_r[addr] <= bit_v;
          sum_r         <= wrap_add(sum_r, ot_tab[np]);
        end
      end
      if (cmd.rs_upd) begin
        off_r[addr] <= sum_r;
        sum_r       <= wrap_add(sum_r, ot_tab[cur_pct]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_data[6:3];
      pin_r <= in_data[13:7];
      dur_r <= in_data[45] ? '0 : in_data[44:14];
    end
    if (cmd.out_load) begin
      oheat_r <= heat_ext[HEAT_W-1:0];
      opct_r  <= readv_r;
    end
  end

  assign heat_ext = {{HEAT_W{1'b0}}, drive_r};
  assign out_data = {7'd0, opct_r, oheat_r};

  assign stat.idx_end  = CNT_W'(idx) >= n_act;
  assign stat.need_div = (op_r == OP_STEP_DOWN) && (cur_pct > 7'd1)
                         && (cur_len < {15'd0, maxd_r});
  assign stat.div_done = div_done;
  assign stat.flag     = flag_r;
endmodule

### design/hpc_ctrl.sv
// Controller state machine: sequences channel walks, divides, restacks and output.
// Depends on hpc_pkg.
module hpc_ctrl #(
  parameter int unsigned CHANNELS = 10,
  parameter int unsigned IW       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpc_pkg::op_t       in_op,
  output logic               out_valid,
  input  logic               out_ready,
  input  hpc_pkg::hpc_stat_t stat,
  output hpc_pkg::hpc_cmd_t  cmd,
  output logic [IW-1:0]      idx
);
  import hpc_pkg::*;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_nxt  = '0;
          unique case (in_op) inside
            OP_TICK, OP_STEP_DOWN, OP_ALL_ON, OP_ALL_OFF: state_nxt = ST_WALK;
            default: state_nxt = ST_SINGLE;
          endcase
        end
      end
      ST_SINGLE: begin
        cmd.use_ch   = 1'b1;
        cmd.chan_upd = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_WALK: begin
        if (stat.idx_end) begin
          state_nxt = ST_CHECK;
        end else if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end else begin
          cmd.chan_upd = 1'b1;
          idx_nxt      = idx_r + 1'b1;
        end
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.chan_upd = 1'b1;
          idx_nxt      = idx_r + 1'b1;
          state_nxt    = ST_WALK;
        end
      end
      ST_CHECK: begin
        idx_nxt = '0;
        if (stat.flag) begin
          cmd.sum_clr = 1'b1;
          state_nxt   = ST_RESTACK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RESTACK: begin
        if (stat.idx_end) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.rs_upd = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx       = idx_r;
  assign out_valid = ov_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(CHANNELS)) else $error("walk index beyond channel count");
  a_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == ST_FINISH) else $error("result captured outside finish");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == ST_DIV_WAIT) else $error("divide launched without wait");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && ov_r && !out_ready) |=> state_r == ST_FINISH)
    else $error("result overwritten while pending");
endmodule

### design/multichannel_heater_pwm_controller.sv
// Top level of the multichannel heater PWM controller.
// Depends on hpc_pkg, hpc_ctrl, hpc_dp (which holds hpc_div).
//
// One transaction in gives exactly one result out. An input is taken only while
// the controller is idle; a finished result sits in an output register so the next
// input can be taken while the result waits. Single-channel ops address one
// channel; ticks, step-down and all-channel ops walk N = min(channels_in_use,
// CHANNELS) channels, and any op that changes a duty adds a restack of phase
// offsets over those N channels. Step-down runs the serial divider once per
// channel whose duty is above one percent and whose on-time lies under the cap.
// Ticks are expected once per ms.
// Config writes are always ready and are meant to happen only while idle.
module multichannel_heater_pwm_controller #(
  parameter int unsigned CHANNELS  = 10,
  parameter int unsigned PERIOD_MS = 1000
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // tdata: opcode[2:0], channel[6:3], duty_percent[13:7], on_time_ms[45:14]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hpc_pkg::IN_W-1:0]   in_tdata,
  // tdata: heater_bits[9:0], percent_read[16:10]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hpc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hpc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [hpc_pkg::MAXD_W-1:0] cfg_data
);
  import hpc_pkg::*;

  localparam int unsigned IW = $clog2(CHANNELS + 1);

  hpc_cmd_t      cmd;
  hpc_stat_t     stat;
  logic [IW-1:0] idx;

  assign cfg_ready = 1'b1;

  hpc_ctrl #(
    .CHANNELS (CHANNELS),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tdata[2:0])),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd),
    .idx       (idx)
  );

  hpc_dp #(
    .CHANNELS  (CHANNELS),
    .PERIOD_MS (PERIOD_MS),
    .IW        (IW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .stat      (stat),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_data  (out_tdata)
  );
endmodule
